>>> design/gan_pkg.sv
// Shared types and constants for the autotile neighbour-mask block.
// Holds the controller/datapath command and status bundles and the offset tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gan_pkg;

  localparam int NB_COUNT = 8;
  localparam int WIN_SIDE = 5;
  localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
  localparam int WIN_CENTER = WIN_CELLS / 2;
  localparam int SLOT_COUNT = NB_COUNT + 1;

  localparam logic signed [2:0] NB_DCOL [NB_COUNT] = '{
    -3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd0, 3'sd1
  };
  localparam logic signed [2:0] NB_DROW [NB_COUNT] = '{
    -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1
  };

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic mul;
    logic chk;
    logic rd_step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic win_full;
    logic act;
    logic slot_last;
  } sts_t;

  function automatic logic [4:0] win_pos(logic signed [2:0] dc, logic signed [2:0] dr);
    logic [2:0] c;
    logic [2:0] r;
    c = 3'(dc + 3'sd2);
    r = 3'(dr + 3'sd2);
    return 5'(r * 3'd5 + {2'b00, c});
  endfunction

endpackage

`default_nettype wire

>>> design/grid_autotile_neighbour_mask.sv
// Top level of the autotile neighbour-mask block.
// Joins gan_ctrl and gan_dp; depends on gan_pkg.
//
// After reset, busy stays high while the occupancy memory is swept clear, one
// cell per cycle. An edit is taken when start is high and busy low. busy then
// stays high while the edit is worked on: an edit whose position falls off the
// grid ends at the range check, one that changes nothing ends after the 25-cell
// window read through the single memory read port, and a real add or remove
// goes on to emit its results. Results come at most one beat per cycle on
// valid_o, at most nine per edit, the last beat marked by last_o and landing no
// later than the first cycle with busy low. Results cannot be held off: the
// receiver must take every beat in the cycle it appears.
`timescale 1ns / 1ps
`default_nettype none

module grid_autotile_neighbour_mask import gan_pkg::*; #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int CELL_SIZE = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  wire        mode_i,
  input  wire [11:0] x_pixel_i,
  input  wire [11:0] y_pixel_i,
  output logic       valid_o,
  output logic [5:0] cell_col_o,
  output logic [5:0] cell_row_o,
  output logic [7:0] mask_o,
  output logic       last_o
);

  cmd_t cmd;
  sts_t sts;

  gan_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  gan_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CELL_SIZE (CELL_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .mode_i     (mode_i),
    .x_pixel_i  (x_pixel_i),
    .y_pixel_i  (y_pixel_i),
    .valid_o    (valid_o),
    .cell_col_o (cell_col_o),
    .cell_row_o (cell_row_o),
    .mask_o     (mask_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

>>> design/gan_ctrl.sv
// Sequencing state machine for the autotile neighbour-mask block.
// Drives datapath commands from datapath status; depends on gan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gan_ctrl import gan_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d = sts_i.in_range ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd_o.rd_step = 1'b1;
        if (sts_i.win_full) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.act) begin
          cmd_o.commit = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.slot_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> design/gan_dp.sv
// Datapath for the autotile neighbour-mask block: cell index, occupancy memory,
// 5x5 window, and mask generation. Depends on gan_pkg; driven by gan_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module gan_dp import gan_pkg::*; #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int CELL_SIZE = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  wire         mode_i,
  input  wire  [11:0] x_pixel_i,
  input  wire  [11:0] y_pixel_i,
  output logic        valid_o,
  output logic [5:0]  cell_col_o,
  output logic [5:0]  cell_row_o,
  output logic [7:0]  mask_o,
  output logic        last_o
);

  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SH    = 12 + $clog2(CELL_SIZE);
  localparam int MW    = SH + 1;
  localparam int PW    = 12 + MW;
  localparam int QW    = PW - SH;
  localparam longint unsigned RECIP = ((64'd1 << SH) + CELL_SIZE - 1) / CELL_SIZE;
  localparam logic [MW-1:0] MUL_K   = MW'(RECIP);
  localparam logic [AW-1:0] COLS_A  = AW'(GRID_COLS);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Input capture and reciprocal multiply
  logic          mode_q;
  logic [11:0]   x_q, y_q;
  logic [PW-1:0] px_q, py_q;
  logic [QW-1:0] qx, qy;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      x_q    <= x_pixel_i;
      y_q    <= y_pixel_i;
    end
    if (cmd_i.mul) begin
      px_q <= PW'(x_q) * PW'(MUL_K);
      py_q <= PW'(y_q) * PW'(MUL_K);
    end
    if (cmd_i.chk) begin
      col_q <= CW'(qx);
      row_q <= RW'(qy);
    end
  end

  assign qx = px_q[PW-1:SH];
  assign qy = py_q[PW-1:SH];
  assign sts_o.in_range = (qx < QW'(GRID_COLS)) && (qy < QW'(GRID_ROWS));

  // Occupancy memory
  logic          mem_q [DEPTH];
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] raddr;
  logic          rdata_q;
  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] ctr_addr;

  assign ctr_addr = AW'(row_q) * COLS_A + AW'(col_q);
  assign we    = cmd_i.clr_step || cmd_i.commit;
  assign waddr = cmd_i.clr_step ? clr_addr_q : ctr_addr;
  assign wdata = cmd_i.clr_step ? 1'b0 : !mode_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign sts_o.clr_done = cmd_i.clr_step && (clr_addr_q == LAST_A);

  // Window read sweep
  logic [2:0]           wc_q, wr_q;
  logic [4:0]           widx_q, ridx_q;
  logic                 iss_q, rvalid_q, rok_q;
  logic signed [CW+1:0] wcol;
  logic signed [RW+1:0] wrow;
  logic                 wok;
  logic [WIN_CELLS-1:0] win_q;

  assign wcol = $signed({2'b00, col_q}) + (CW+2)'($signed({1'b0, wc_q}) - 4'sd2);
  assign wrow = $signed({2'b00, row_q}) + (RW+2)'($signed({1'b0, wr_q}) - 4'sd2);
  assign wok  = !wcol[CW+1] && !wrow[RW+1] &&
                ($unsigned(wcol) < (CW+2)'(GRID_COLS)) &&
                ($unsigned(wrow) < (RW+2)'(GRID_ROWS));
  assign raddr = wok ? (AW'(wrow[RW-1:0]) * COLS_A + AW'(wcol[CW-1:0])) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q    <= 1'b0;
      rvalid_q <= 1'b0;
      wc_q     <= '0;
      wr_q     <= '0;
      widx_q   <= '0;
    end else begin
      rvalid_q <= cmd_i.rd_step && iss_q;
      if (cmd_i.chk) begin
        iss_q  <= 1'b1;
        wc_q   <= '0;
        wr_q   <= '0;
        widx_q <= '0;
      end else if (cmd_i.rd_step && iss_q) begin
        widx_q <= widx_q + 5'd1;
        if (wc_q == 3'(WIN_SIDE - 1)) begin
          wc_q <= '0;
          wr_q <= wr_q + 3'd1;
          if (wr_q == 3'(WIN_SIDE - 1)) iss_q <= 1'b0;
        end else begin
          wc_q <= wc_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= widx_q;
    rok_q  <= wok;
    if (cmd_i.chk) begin
      win_q <= '0;
    end else if (rvalid_q) begin
      win_q[ridx_q] <= rdata_q && rok_q;
    end else if (cmd_i.commit) begin
      win_q[WIN_CENTER] <= !mode_q;
    end
  end

  assign sts_o.win_full = rvalid_q && (ridx_q == 5'(WIN_CELLS - 1));
  assign sts_o.act = mode_q ? win_q[WIN_CENTER] : !win_q[WIN_CENTER];

  // Result slots: center on add, then occupied neighbours in offset order
  logic [3:0]              slot_q;
  logic [2:0]              slot_nb;
  logic signed [2:0]       bdc, bdr;
  logic [SLOT_COUNT-1:0]   qual;
  logic [SLOT_COUNT:0]     upto;
  logic                    none_after;
  logic [7:0]              mask;
  logic signed [CW+1:0]    ecol;
  logic signed [RW+1:0]    erow;

  assign slot_nb = 3'(slot_q - 4'd1);

  always_comb begin
    qual[0] = !mode_q;
    for (int k = 0; k < NB_COUNT; k++) begin
      qual[k+1] = win_q[win_pos(NB_DCOL[k], NB_DROW[k])];
    end
    if (slot_q == '0) begin
      bdc = 3'sd0;
      bdr = 3'sd0;
    end else begin
      bdc = NB_DCOL[slot_nb];
      bdr = NB_DROW[slot_nb];
    end
    for (int j = 0; j < NB_COUNT; j++) begin
      mask[j] = win_q[win_pos(3'(bdc + NB_DCOL[j]), 3'(bdr + NB_DROW[j]))];
    end
  end

  assign upto       = ((SLOT_COUNT+1)'(2) << slot_q) - (SLOT_COUNT+1)'(1);
  assign none_after = ((qual & ~upto[SLOT_COUNT-1:0]) == '0);
  assign ecol = $signed({2'b00, col_q}) + (CW+2)'(bdc);
  assign erow = $signed({2'b00, row_q}) + (RW+2)'(bdr);
  assign sts_o.slot_last = (slot_q == 4'(SLOT_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.emit && qual[slot_q];
      if (cmd_i.chk) begin
        slot_q <= '0;
      end else if (cmd_i.emit) begin
        slot_q <= slot_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      cell_col_o <= 6'($unsigned(ecol));
      cell_row_o <= 6'($unsigned(erow));
      mask_o     <= mask;
      last_o     <= none_after;
    end
  end

  // Checks
  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result after last beat");

  a_commit_after_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !rvalid_q && !iss_q)
    else $error("commit while window read pending");

  a_center_follows_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.commit) |-> win_q[WIN_CENTER] == !mode_q)
    else $error("window center disagrees with edit");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for grid_autotile_neighbour_mask: directed and random tile edits,
// every result beat checked against typed plan rows or an occupancy-map predictor kept in the bench.
// Depends only on the RTL under design/.
`timescale 1ns / 1ps

module tb;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int CELL_SIZE = 64;
  localparam int NB_COUNT = 8;
  localparam int EDITS_PER_PHASE = 27;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;

  localparam int NB_DC [NB_COUNT] = '{-1, 0, 1, -1, 1, -1, 0, 1};
  localparam int NB_DR [NB_COUNT] = '{-1, -1, -1, 0, 0, 1, 1, 1};
  localparam int SEND_IDLE_PCT [4] = '{0, 64, 0, 37};

  typedef enum bit {EDIT_PLACE = 1'b0, EDIT_REMOVE = 1'b1} edit_e;

  typedef struct packed {
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] mask;
    logic       last;
  } tile_beat_t;

  typedef struct packed {
    bit         typed;
    edit_e      mode;
    logic [11:0] x;
    logic [11:0] y;
    bit         one_beat;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] mask;
  } edit_row_t;

  // typed rows carry the whole expected outcome; the rest go through the predictor
  localparam edit_row_t EDIT_PLAN [22] = '{
    '{1'b1, EDIT_PLACE,     0,    0, 1'b1,  0,  0, 8'h00},
    '{1'b1, EDIT_REMOVE,   64,    0, 1'b0,  0,  0, 8'h00},
    '{1'b1, EDIT_PLACE,  4095, 4095, 1'b1, 63, 63, 8'h00},
    '{1'b1, EDIT_PLACE,  4032, 4090, 1'b0,  0,  0, 8'h00},
    '{1'b1, EDIT_PLACE,  4095,    0, 1'b1, 63,  0, 8'h00},
    '{1'b1, EDIT_PLACE,     0, 4095, 1'b1,  0, 63, 8'h00},
    '{1'b0, EDIT_PLACE,   576,  576, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   703,  600, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   767,  639, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   600,  650, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   704,  700, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   639,  704, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   641,  767, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   766,  720, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   672,  672, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_REMOVE,  700,  641, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_REMOVE,  577,  630, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,   127,   63, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_REMOVE,    5,   60, 1'b0,  0,  0, 8'h00},
    '{1'b0, EDIT_PLACE,  3968, 4095, 1'b0,  0,  0, 8'h00},
    '{1'b1, EDIT_REMOVE, 4095,   63, 1'b0,  0,  0, 8'h00},
    '{1'b1, EDIT_REMOVE, 1234, 2345, 1'b0,  0,  0, 8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        mode_i = 1'b0;
  logic [11:0] x_pixel_i = '0;
  logic [11:0] y_pixel_i = '0;
  wire         busy;
  wire         valid_o;
  wire  [5:0]  cell_col_o;
  wire  [5:0]  cell_row_o;
  wire  [7:0]  mask_o;
  wire         last_o;

  bit          occ [GRID_ROWS][GRID_COLS];
  tile_beat_t  edit_beats [$];
  tile_beat_t  pending_masks [$];
  int          mismatches = 0;
  int          cycles = 0;

  grid_autotile_neighbour_mask #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS),
    .CELL_SIZE(CELL_SIZE)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .mode_i    (mode_i),
    .x_pixel_i (x_pixel_i),
    .y_pixel_i (y_pixel_i),
    .valid_o   (valid_o),
    .cell_col_o(cell_col_o),
    .cell_row_o(cell_row_o),
    .mask_o    (mask_o),
    .last_o    (last_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit occupied(int c, int r);
    if (c < 0 || r < 0 || c >= GRID_COLS || r >= GRID_ROWS) return 1'b0;
    return occ[r][c];
  endfunction

  function automatic logic [7:0] mask_at(int c, int r);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < NB_COUNT; k++) m[k] = occupied(c + NB_DC[k], r + NB_DR[k]);
    return m;
  endfunction

  task automatic predict_edit(edit_e md, logic [11:0] x, logic [11:0] y);
    int c;
    int r;
    int nc;
    int nr;
    tile_beat_t b;
    c = x / CELL_SIZE;
    r = y / CELL_SIZE;
    edit_beats.delete();
    if (c >= GRID_COLS || r >= GRID_ROWS) return;
    if (md == EDIT_PLACE) begin
      if (occ[r][c]) return;
      occ[r][c] = 1'b1;
      b.col = c[5:0];
      b.row = r[5:0];
      b.mask = mask_at(c, r);
      b.last = 1'b0;
      edit_beats.push_back(b);
    end else begin
      if (!occ[r][c]) return;
      occ[r][c] = 1'b0;
    end
    for (int k = 0; k < NB_COUNT; k++) begin
      nc = c + NB_DC[k];
      nr = r + NB_DR[k];
      if (occupied(nc, nr)) begin
        b.col = nc[5:0];
        b.row = nr[5:0];
        b.mask = mask_at(nc, nr);
        b.last = 1'b0;
        edit_beats.push_back(b);
      end
    end
    if (edit_beats.size() > 0) edit_beats[edit_beats.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // hold the edit until busy is low at a falling edge; the next rising edge takes it
  task automatic send_edit(edit_e md, logic [11:0] x, logic [11:0] y, bit typed,
                           bit one_beat, tile_beat_t typed_beat);
    start <= 1'b1;
    mode_i <= md;
    x_pixel_i <= x;
    y_pixel_i <= y;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    predict_edit(md, x, y);
    if (typed) begin
      if (one_beat) pending_masks.push_back(typed_beat);
    end else begin
      foreach (edit_beats[i]) pending_masks.push_back(edit_beats[i]);
    end
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 48)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_masks.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : check_beats
    tile_beat_t want;
    if (rst_ni && valid_o) begin
      if (pending_masks.size() == 0) begin
        report_mismatch("beat with nothing pending, col", cell_col_o, -1);
      end else begin
        want = pending_masks.pop_front();
        if (cell_col_o !== want.col) report_mismatch("cell_col", cell_col_o, want.col);
        if (cell_row_o !== want.row) report_mismatch("cell_row", cell_row_o, want.row);
        if (mask_o !== want.mask) report_mismatch("mask", mask_o, want.mask);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  initial begin
    int done;
    int base_c;
    int base_r;
    int c;
    int r;
    edit_e md;
    logic [11:0] x;
    logic [11:0] y;
    tile_beat_t b;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (EDIT_PLAN[i]) begin
      b.col = EDIT_PLAN[i].col;
      b.row = EDIT_PLAN[i].row;
      b.mask = EDIT_PLAN[i].mask;
      b.last = 1'b1;
      send_edit(EDIT_PLAN[i].mode, EDIT_PLAN[i].x, EDIT_PLAN[i].y, EDIT_PLAN[i].typed,
                EDIT_PLAN[i].one_beat, b);
    end
    drain_results();

    // edits mostly land in a 4x4 patch so neighbours exist; some land anywhere
    for (int phase = 0; phase < 4; phase++) begin
      base_c = (phase == 0) ? 0 : (phase == 1) ? 60 : $urandom_range(0, 60);
      base_r = (phase == 0) ? 0 : (phase == 1) ? 60 : $urandom_range(0, 60);
      done = 0;
      while (done < EDITS_PER_PHASE) begin
        idle_gap(SEND_IDLE_PCT[phase]);
        md = edit_e'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
          x = 12'($urandom_range(0, 4095));
          y = 12'($urandom_range(0, 4095));
        end else begin
          c = base_c + $urandom_range(0, 3);
          r = base_r + $urandom_range(0, 3);
          x = 12'(c * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1));
          y = 12'(r * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1));
        end
        send_edit(md, x, y, 1'b0, 1'b0, '0);
        done++;
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_masks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
